FILE: rtl/sine_shaper_unit_range_defines.svh
// assertion macros for the sine shaper
`ifndef SINE_SHAPER_UNIT_RANGE_DEFINES_SVH
`define SINE_SHAPER_UNIT_RANGE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// combinational implication, checked at every edge out of reset
`define SSUR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sine shaper check failed");
// implication whose consequence is checked in the following cycle
`define SSUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sine shaper check failed");
`else
`define SSUR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSUR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ssur_pkg.sv
package ssur_pkg;

    localparam int unsigned POS_W    = 17;
    localparam int unsigned CYC_W    = 15;
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned ANG_W    = 24;
    localparam int unsigned QTR_W    = 22;
    localparam int unsigned X_W      = QTR_W + 1;
    localparam int unsigned Q_W      = 31;
    localparam int unsigned MAP_W    = 17;
    localparam int unsigned NUM_CELLS = 4;

    localparam logic [CYC_W-1:0] CYCLES_RST = CYC_W'(256);
    localparam logic [VAL_W-1:0] PHASE_RST  = '0;

    localparam logic [0:0] CFG_CYCLES = 1'b0;
    localparam logic [0:0] CFG_PHASE  = 1'b1;

    localparam logic [Q_W-1:0] Q30_ONE = Q_W'(1073741824);
    localparam logic [Q_W-1:0] COEF_S9 = Q_W'(172272);

    // horner coefficients, first cell to last
    localparam logic [Q_W-1:0] CELL_COEF [NUM_CELLS] = '{
        Q_W'(5026995),
        Q_W'(85569306),
        Q_W'(693598668),
        Q_W'(1686629713)
    };

    localparam logic [MAP_W-1:0] MAPPED_MAX = MAP_W'(65536);
    localparam logic [VAL_W-1:0] VALUE_MAX  = VAL_W'(65535);

    // per-item sideband carried down the pipe
    typedef struct packed {
        logic             neg;
        logic             head;
        logic [VAL_W-1:0] prior;
    } t_side;

endpackage

FILE: rtl/ssur_cell.sv
module ssur_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  ssur_pkg::t_side             i_side,
    input  logic [ssur_pkg::X_W-1:0]    i_x,
    input  logic [ssur_pkg::Q_W-1:0]    i_t2,
    input  logic [ssur_pkg::Q_W-1:0]    i_p,
    input  logic [ssur_pkg::Q_W-1:0]    i_coef,
    input  logic                        i_en,
    output logic                        o_en,
    output logic                        o_valid,
    output ssur_pkg::t_side             o_side,
    output logic [ssur_pkg::X_W-1:0]    o_x,
    output logic [ssur_pkg::Q_W-1:0]    o_t2,
    output logic [ssur_pkg::Q_W-1:0]    o_p
);

    logic                       r_valid;
    ssur_pkg::t_side            r_side;
    logic [ssur_pkg::X_W-1:0]   r_x;
    logic [ssur_pkg::Q_W-1:0]   r_t2;
    logic [ssur_pkg::Q_W-1:0]   r_p;
    logic [2*ssur_pkg::Q_W-1:0] prod;
    logic [ssur_pkg::Q_W-1:0]   n_p;

    // one horner step: p = c - (t2 * p) >> 30
    assign prod = i_t2 * i_p;
    assign n_p  = i_coef - prod[2*ssur_pkg::Q_W-2:ssur_pkg::Q_W-1];
    assign o_en = !r_valid || i_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            r_side <= i_side;
            r_x    <= i_x;
            r_t2   <= i_t2;
            r_p    <= n_p;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_x     = r_x;
    assign o_t2    = r_t2;
    assign o_p     = r_p;

endmodule

FILE: rtl/sine_shaper_unit_range.sv
// a request is registered in stage 0, then stage 1, the four horner cells and
//   stages 6, 7 and 8; o_valid is stage 8's valid and its result leaves on i_ready
// throughput: one request per cycle unless i_ready stalls the result side, set by the
//   pipeline of angle, square, four horner cells, magnitude, map and output multiply stages
// a stage holding a request takes the next one as soon as its result moves on
// reset (synchronous, active low) empties the pipe, cycles = 1.0, phase = 0
`include "sine_shaper_unit_range_defines.svh"

module sine_shaper_unit_range (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ssur_pkg::POS_W-1:0]      i_position,
    input  logic [ssur_pkg::VAL_W-1:0]      i_prior_value,
    input  logic                            i_head,
    // result side
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ssur_pkg::VAL_W-1:0]      o_value,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [ssur_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int unsigned NC = ssur_pkg::NUM_CELLS;

    // configuration registers
    logic [ssur_pkg::CYC_W-1:0] r_cycles;
    logic [ssur_pkg::VAL_W-1:0] r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles <= ssur_pkg::CYCLES_RST;
            r_phase  <= ssur_pkg::PHASE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssur_pkg::CFG_CYCLES: r_cycles <= i_cfg_data[ssur_pkg::CYC_W-1:0];
                ssur_pkg::CFG_PHASE:  r_phase  <= i_cfg_data;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its content moves on
    logic             en0, en1, en6, en7, en8;
    logic             c_en [NC+1];
    logic             c_v  [NC+1];
    ssur_pkg::t_side  c_side [NC+1];
    logic [ssur_pkg::X_W-1:0] c_x  [NC+1];
    logic [ssur_pkg::Q_W-1:0] c_t2 [NC+1];
    logic [ssur_pkg::Q_W-1:0] c_p  [NC+1];

    // stage 0: angle in turns, q0.24, wrapped
    logic                         r0_v;
    ssur_pkg::t_side              r0_side;
    logic [ssur_pkg::ANG_W-1:0]   r0_ang;
    logic [ssur_pkg::POS_W+ssur_pkg::CYC_W-1:0] ang_prod;
    logic [ssur_pkg::ANG_W-1:0]   n_ang;
    ssur_pkg::t_side              in_side;

    assign ang_prod = i_position * r_cycles;
    assign n_ang    = ang_prod[ssur_pkg::ANG_W-1:0] + {r_phase, 8'h00};
    assign in_side  = '{neg: 1'b0, head: i_head, prior: i_prior_value};

    assign en0     = !r0_v || en1;
    assign o_ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en0) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r0_ang  <= n_ang;
            r0_side <= in_side;
        end
    end

    // stage 1: quadrant fold and t squared (t = x << 8, so t*t >> 30 = x*x >> 14)
    logic                         r1_v;
    ssur_pkg::t_side              r1_side;
    logic [ssur_pkg::X_W-1:0]     r1_x;
    logic [ssur_pkg::Q_W-1:0]     r1_t2;
    logic [1:0]                   quad;
    logic [ssur_pkg::X_W-1:0]     x_raw;
    logic [ssur_pkg::X_W-1:0]     x_fold;
    logic [2*ssur_pkg::X_W-1:0]   x_sq;
    ssur_pkg::t_side              side1;

    assign quad   = r0_ang[ssur_pkg::ANG_W-1:ssur_pkg::QTR_W];
    assign x_raw  = {1'b0, r0_ang[ssur_pkg::QTR_W-1:0]};
    // odd quadrants run the quarter wave backward
    assign x_fold = quad[0] ? ((ssur_pkg::X_W'(1) << ssur_pkg::QTR_W) - x_raw) : x_raw;
    assign x_sq   = x_fold * x_fold;

    always_comb begin
        side1     = r0_side;
        side1.neg = quad[1];
    end

    assign en1 = !r1_v || c_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && r0_v) begin
            r1_side <= side1;
            r1_x    <= x_fold;
            r1_t2   <= x_sq[ssur_pkg::Q_W+13:14];
        end
    end

    // horner chain, one coefficient per cell, starting from s9
    assign c_v[0]    = r1_v;
    assign c_side[0] = r1_side;
    assign c_x[0]    = r1_x;
    assign c_t2[0]   = r1_t2;
    assign c_p[0]    = ssur_pkg::COEF_S9;
    assign c_en[NC]  = en6;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        ssur_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[k]),
            .i_side  (c_side[k]),
            .i_x     (c_x[k]),
            .i_t2    (c_t2[k]),
            .i_p     (c_p[k]),
            .i_coef  (ssur_pkg::CELL_COEF[k]),
            .i_en    (c_en[k+1]),
            .o_en    (c_en[k]),
            .o_valid (c_v[k+1]),
            .o_side  (c_side[k+1]),
            .o_x     (c_x[k+1]),
            .o_t2    (c_t2[k+1]),
            .o_p     (c_p[k+1])
        );
    end

    // stage 6: magnitude = t * p >> 30 = x * p >> 22, clamped to one
    logic                         r6_v;
    ssur_pkg::t_side              r6_side;
    logic [ssur_pkg::Q_W-1:0]     r6_mag;
    logic [ssur_pkg::X_W+ssur_pkg::Q_W-1:0] mag_prod;
    logic [ssur_pkg::Q_W:0]       mag_raw;
    logic [ssur_pkg::Q_W-1:0]     mag_clamp;

    assign mag_prod  = c_x[NC] * c_p[NC];
    assign mag_raw   = mag_prod[ssur_pkg::X_W+ssur_pkg::Q_W-1:ssur_pkg::QTR_W];
    assign mag_clamp = (mag_raw > {1'b0, ssur_pkg::Q30_ONE}) ? ssur_pkg::Q30_ONE
                                                             : mag_raw[ssur_pkg::Q_W-1:0];

    assign en6 = !r6_v || en7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en6) begin
            r6_v <= c_v[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6 && c_v[NC]) begin
            r6_side <= c_side[NC];
            r6_mag  <= mag_clamp;
        end
    end

    // stage 7: bias by one, round to q0.16 (range 0 to 65536)
    logic                         r7_v;
    ssur_pkg::t_side              r7_side;
    logic [ssur_pkg::MAP_W-1:0]   r7_mapped;
    logic [ssur_pkg::Q_W:0]       biased;
    logic [ssur_pkg::Q_W:0]       biased_rnd;

    assign biased     = r6_side.neg ? ({1'b0, ssur_pkg::Q30_ONE} - {1'b0, r6_mag})
                                    : ({1'b0, ssur_pkg::Q30_ONE} + {1'b0, r6_mag});
    assign biased_rnd = biased + (ssur_pkg::Q_W+1)'(16384);

    assign en7 = !r7_v || en8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en7) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7 && r6_v) begin
            r7_side   <= r6_side;
            r7_mapped <= biased_rnd[ssur_pkg::Q_W:15];
        end
    end

    // stage 8: head passes the mapped sine, otherwise scale the prior value
    logic                         r8_v;
    logic [ssur_pkg::VAL_W-1:0]   r8_value;
    logic [ssur_pkg::VAL_W+ssur_pkg::MAP_W-1:0] mod_prod;
    logic [ssur_pkg::VAL_W+ssur_pkg::MAP_W-1:0] mod_rnd;
    logic [ssur_pkg::MAP_W-1:0]   pick;
    logic [ssur_pkg::VAL_W-1:0]   n_value;

    assign mod_prod = r7_side.prior * r7_mapped;
    assign mod_rnd  = mod_prod + (ssur_pkg::VAL_W+ssur_pkg::MAP_W)'(32768);
    assign pick     = r7_side.head ? r7_mapped
                                   : mod_rnd[ssur_pkg::VAL_W+ssur_pkg::MAP_W-1:16];
    // saturate the full-scale sine
    assign n_value  = pick[ssur_pkg::MAP_W-1] ? ssur_pkg::VALUE_MAX
                                              : pick[ssur_pkg::VAL_W-1:0];

    assign en8 = !r8_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en8) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en8 && r7_v) begin
            r8_value <= n_value;
        end
    end

    assign o_valid = r8_v;
    assign o_value = r8_value;

    // pipe full: every stage holds a request when the input side stalls
    logic all_full;
    assign all_full = r0_v && r1_v && c_v[1] && c_v[2] && c_v[3] && c_v[4]
                      && r6_v && r7_v && r8_v;

    `SSUR_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !o_ready, all_full)
    `SSUR_ASSERT_NOW(a_mag_clamp, i_clk, i_rst_n, r6_v, r6_mag <= ssur_pkg::Q30_ONE)
    `SSUR_ASSERT_NOW(a_map_range, i_clk, i_rst_n, r7_v, r7_mapped <= ssur_pkg::MAPPED_MAX)
    `SSUR_ASSERT_NEXT(a_out_moves, i_clk, i_rst_n, r7_v && en8, o_valid)

endmodule
